FILE: rtl/core/steering_tag_region_table_defines.svh
// assertion macros for the steering tag region table
// no dependencies; included by the files that assert
`ifndef STEERING_TAG_REGION_TABLE_DEFINES_SVH
`define STEERING_TAG_REGION_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define STRT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define STRT_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define STRT_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define STRT_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

FILE: rtl/core/strt_pkg.sv
// types, codes and constants shared by the steering tag region table
// no dependencies
package strt_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 16;
    localparam int ENTRY_IDX_W           = 8;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_DEREGISTER = 2'd1,
        OP_CHECK      = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NOT_FOUND    = 2'd1,
        STATUS_OUT_OF_RANGE = 2'd2,
        STATUS_FULL         = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                   active;
        logic [31:0]            key;
        logic                   found;
        logic [ENTRY_IDX_W-1:0] found_idx;
        logic                   free;
        logic [ENTRY_IDX_W-1:0] free_idx;
        logic [63:0]            hit_base;
        logic [31:0]            hit_len;
    } tok_t;

    typedef struct packed {
        logic                   en;
        logic                   clr;
        logic [ENTRY_IDX_W-1:0] idx;
        logic [31:0]            tag;
        logic [63:0]            base;
        logic [31:0]            len;
    } wr_t;

endpackage

FILE: rtl/core/strt_cell.sv
// one table entry: holds tag, base and length and passes the lookup beat on
// depends on strt_pkg
module strt_cell
    import strt_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  tok_t tok_in,
    output tok_t tok_out,
    input  wr_t  wr
);

    logic        valid_reg;
    logic [31:0] tag_reg;
    logic [63:0] base_reg;
    logic [31:0] len_reg;
    logic        active_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        wr_hit;

    assign wr_hit = wr.en && (wr.idx == ENTRY_IDX_W'(IDX));

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && valid_reg && !tok_in.found && tag_reg == tok_in.key)
        begin
            tok_next.found     = 1'b1;
            tok_next.found_idx = ENTRY_IDX_W'(IDX);
            tok_next.hit_base  = base_reg;
            tok_next.hit_len   = len_reg;
        end
        if (tok_in.active && !valid_reg && !tok_in.free)
        begin
            tok_next.free     = 1'b1;
            tok_next.free_idx = ENTRY_IDX_W'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= tok_in.active;
            if (wr_hit)
            begin
                valid_reg <= !wr.clr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (wr_hit && !wr.clr)
        begin
            tag_reg  <= wr.tag;
            base_reg <= wr.base;
            len_reg  <= wr.len;
        end
    end

    always_comb
    begin
        tok_out        = tok_reg;
        tok_out.active = active_reg;
    end

endmodule

FILE: rtl/core/strt_ctrl.sv
// sequencer: takes a request, launches it down the cell chain, decides and
// commits the table update, and holds the result beat; depends on strt_pkg
module strt_ctrl
    import strt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,
    output tok_t         tok_first,
    input  tok_t         tok_last,
    output wr_t          wr
);

    state_t       state_reg;
    state_t       state_next;
    logic [1:0]   op_reg;
    logic [63:0]  base_reg;
    logic [31:0]  len_reg;
    logic [63:0]  off_reg;
    logic [130:0] res_reg;
    logic [130:0] res_next;
    logic         m_tvalid_reg;
    logic         m_tvalid_next;
    logic [135:0] m_tdata_reg;
    logic         accept;
    logic         arrive;
    logic         load;
    logic [63:0]  diff;
    logic [1:0]   status;
    logic [31:0]  atag;
    logic         removed;
    logic [63:0]  hbase;
    logic [31:0]  hlen;

    assign accept = s_tvalid && s_tready;
    assign arrive = (state_reg == S_WALK) && tok_last.active;
    assign load   = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (tok_last.active)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == S_IDLE);

        tok_first        = '0;
        tok_first.active = accept;
        tok_first.key    = (s_tuser == OP_REGISTER) ? s_tdata[63:32] : s_tdata[31:0];

        diff    = off_reg - tok_last.hit_base;
        status  = STATUS_OK;
        atag    = '0;
        removed = 1'b0;
        hbase   = '0;
        hlen    = '0;
        wr      = '0;
        wr.tag  = base_reg[31:0];
        wr.base = base_reg;
        wr.len  = len_reg;

        unique case (op_reg)
            OP_REGISTER:
            begin
                atag = base_reg[31:0];
                if (tok_last.found)
                begin
                    wr.en  = arrive;
                    wr.idx = tok_last.found_idx;
                end
                else if (tok_last.free)
                begin
                    wr.en  = arrive;
                    wr.idx = tok_last.free_idx;
                end
                else
                begin
                    status = STATUS_FULL;
                end
            end
            OP_DEREGISTER:
            begin
                if (tok_last.found)
                begin
                    wr.en   = arrive;
                    wr.clr  = 1'b1;
                    wr.idx  = tok_last.found_idx;
                    removed = 1'b1;
                end
                else
                begin
                    status = STATUS_NOT_FOUND;
                end
            end
            OP_CHECK:
            begin
                if (tok_last.found)
                begin
                    hbase = tok_last.hit_base;
                    hlen  = tok_last.hit_len;
                    if (off_reg < tok_last.hit_base || diff > {32'd0, tok_last.hit_len})
                    begin
                        status = STATUS_OUT_OF_RANGE;
                    end
                end
                else
                begin
                    status = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                status = STATUS_OK;
            end
        endcase

        res_next      = {hlen, hbase, removed, atag, status};
        m_tvalid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        m_tvalid      = m_tvalid_reg;
        m_tdata       = m_tdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_tuser;
            base_reg <= s_tdata[95:32];
            len_reg  <= s_tdata[127:96];
            off_reg  <= s_tdata[191:128];
        end
        if (arrive)
        begin
            res_reg <= res_next;
        end
        if (load)
        begin
            m_tdata_reg <= {5'd0, res_reg};
        end
    end

endmodule

FILE: rtl/core/steering_tag_region_table.sv
// steering tag region table: a row of entry cells searched by a beat that
// moves one cell per cycle. the result is held in an output register until
// taken; a new request is accepted only when the controller is idle again.
// rst_n is asynchronous, active low, and empties the table at once.
// depends on strt_pkg, strt_ctrl, strt_cell and the defines header
`include "steering_tag_region_table_defines.svh"

module steering_tag_region_table
    import strt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // key_tag, base_address, region_length, target_offset
    input  logic [191:0] s_tdata,
    // opcode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, assigned_tag, removed, hit_base, hit_length, zero pad
    output logic [135:0] m_tdata
);

    tok_t                 tok [TABLE_ENTRIES+1];
    wr_t                  wr;
    logic [TABLE_ENTRIES:0] tok_active;

    strt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .tok_first (tok[0]),
        .tok_last  (tok[TABLE_ENTRIES]),
        .wr        (wr)
    );

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        strt_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .wr      (wr)
        );
    end

    for (genvar i = 0; i <= TABLE_ENTRIES; i++)
    begin : g_active
        assign tok_active[i] = tok[i].active;
    end

    `STRT_ASSERT_ALWAYS(a_single_beat, clk, rst_n, $onehot0(tok_active))
    `STRT_ASSERT_NEXT(a_launch, clk, rst_n, s_tvalid && s_tready, tok_active[1])
    `STRT_ASSERT_NEXT(a_busy_after_walk, clk, rst_n, tok_active[TABLE_ENTRIES], !s_tready)
    `STRT_ASSERT_ALWAYS(a_commit_in_walk, clk, rst_n, !wr.en || tok_active[TABLE_ENTRIES])

endmodule
